[hdl/dnsp_pkg.sv]
// ----------------------------------------------------------------------------
// dnsp_pkg: shared types and constants of the DNS A record parser
// Parse phases, result status codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package dnsp_pkg;

	// parse phases: the parts of the message being walked and the end states
	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_QNAME   = 4'd1,
		PH_QLABEL  = 4'd2,
		PH_QTAIL   = 4'd3,
		PH_ANAME   = 4'd4,
		PH_ALABEL  = 4'd5,
		PH_APTR    = 4'd6,
		PH_AFIXED  = 4'd7,
		PH_ADATA   = 4'd8,
		PH_AADDR   = 4'd9,
		PH_NOTRESP = 4'd11,
		PH_RCODE   = 4'd12,
		PH_NOANS   = 4'd13,
		PH_NOA     = 4'd14
	} phase_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_FOUND   = 3'd0,
		ST_SHORT   = 3'd1,
		ST_NOTRESP = 3'd2,
		ST_RCODE   = 3'd3,
		ST_NOANS   = 3'd4,
		ST_NOA     = 3'd5
	} status_t;

	// field positions inside the header, the fixed record part and the address
	localparam logic [3:0] HDR_FLAGS_HI  = 4'd2;
	localparam logic [3:0] HDR_FLAGS_LO  = 4'd3;
	localparam logic [3:0] HDR_QD_HI     = 4'd4;
	localparam logic [3:0] HDR_QD_LO     = 4'd5;
	localparam logic [3:0] HDR_AN_HI     = 4'd6;
	localparam logic [3:0] HDR_AN_LO     = 4'd7;
	localparam logic [3:0] HDR_LAST_IDX  = 4'd11;
	localparam logic [3:0] FX_TYPE_HI    = 4'd0;
	localparam logic [3:0] FX_TYPE_LO    = 4'd1;
	localparam logic [3:0] FX_CLASS_HI   = 4'd2;
	localparam logic [3:0] FX_CLASS_LO   = 4'd3;
	localparam logic [3:0] FX_DLEN_HI    = 4'd8;
	localparam logic [3:0] FX_LAST_IDX   = 4'd9;
	localparam logic [3:0] ADDR_LAST_IDX = 4'd3;

	// protocol constants
	localparam logic [1:0]  PTR_MARK    = 2'b11;
	localparam logic [15:0] TYPE_A      = 16'd1;
	localparam logic [15:0] CLASS_IN    = 16'd1;
	localparam logic [15:0] A_DATA_LEN  = 16'd4;
	localparam logic [15:0] QTAIL_PLAIN = 16'd4;
	localparam logic [15:0] QTAIL_PTR   = 16'd5;

	// one message byte held in the input register
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} in_item_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [31:0] address;
	} result_t;

endpackage

[hdl/dnsp_in_stage.sv]
// ----------------------------------------------------------------------------
// dnsp_in_stage: input register of the parser
// Takes one message byte per request and holds it until the parser advances.
// ----------------------------------------------------------------------------
module dnsp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte
	input  logic               s_tlast,   // last_byte
	input  logic               adv,
	output dnsp_pkg::in_item_t item
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] data_s1;

	// accept when empty or when the held byte moves on this cycle
	assign s_tready = !valid_s1 || adv;

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// capture the payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign item.valid = valid_s1;
	assign item.last  = last_s1;
	assign item.data  = data_s1;

endmodule

[hdl/dnsp_parse_core.sv]
// ----------------------------------------------------------------------------
// dnsp_parse_core: message walker of the parser
// Updates the parse state for each byte and forms the result of a message.
// ----------------------------------------------------------------------------
module dnsp_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  dnsp_pkg::in_item_t  item,
	input  logic                adv,
	output logic                emit,
	output dnsp_pkg::result_t   res
);

	dnsp_pkg::phase_t phase_q, phase_d;
	logic [3:0]  field_q, field_d;
	logic        resp_q, resp_d;
	logic [3:0]  rcode_q, rcode_d;
	logic [15:0] qleft_q, qleft_d;
	logic [15:0] aleft_q, aleft_d;
	logic [15:0] skip_q, skip_d;
	logic [15:0] rtype_q, rtype_d;
	logic [15:0] rclass_q, rclass_d;
	logic [7:0]  dlen_hi_q, dlen_hi_d;
	logic [31:0] addr_q, addr_d;
	logic        decided_q, decided_d;
	logic        found;
	logic [7:0]  b;
	logic [15:0] dlen;
	logic [15:0] qdec;
	logic [15:0] adec;
	logic [15:0] sdec;

	assign b    = item.data;
	assign dlen = {dlen_hi_q, b};
	assign qdec = qleft_q - 16'd1;
	assign adec = aleft_q - 16'd1;
	assign sdec = skip_q - 16'd1;

	// next state: walk header, questions and answers
	always_comb begin
		phase_d   = phase_q;
		field_d   = field_q;
		resp_d    = resp_q;
		rcode_d   = rcode_q;
		qleft_d   = qleft_q;
		aleft_d   = aleft_q;
		skip_d    = skip_q;
		rtype_d   = rtype_q;
		rclass_d  = rclass_q;
		dlen_hi_d = dlen_hi_q;
		addr_d    = addr_q;
		decided_d = decided_q;
		if (!decided_q) begin
			case (phase_q)
				dnsp_pkg::PH_HDR: begin
					case (field_q)
						dnsp_pkg::HDR_FLAGS_HI: resp_d = b[7];
						dnsp_pkg::HDR_FLAGS_LO: rcode_d = b[3:0];
						dnsp_pkg::HDR_QD_HI: qleft_d = {b, qleft_q[7:0]};
						dnsp_pkg::HDR_QD_LO: qleft_d = {qleft_q[15:8], b};
						dnsp_pkg::HDR_AN_HI: aleft_d = {b, aleft_q[7:0]};
						dnsp_pkg::HDR_AN_LO: aleft_d = {aleft_q[15:8], b};
						default: ;
					endcase
					if (field_q >= dnsp_pkg::HDR_LAST_IDX) begin
						field_d = 4'd0;
						if (!resp_q) begin
							phase_d = dnsp_pkg::PH_NOTRESP;
						end else if (rcode_q != 4'd0) begin
							phase_d = dnsp_pkg::PH_RCODE;
						end else if (aleft_q == 16'd0) begin
							phase_d = dnsp_pkg::PH_NOANS;
						end else if (qleft_q == 16'd0) begin
							phase_d = dnsp_pkg::PH_ANAME;
						end else begin
							phase_d = dnsp_pkg::PH_QNAME;
						end
					end else begin
						field_d = field_q + 4'd1;
					end
				end
				dnsp_pkg::PH_QNAME: begin
					if (b == 8'd0) begin
						skip_d  = dnsp_pkg::QTAIL_PLAIN;
						phase_d = dnsp_pkg::PH_QTAIL;
					end else if (b[7:6] == dnsp_pkg::PTR_MARK) begin
						skip_d  = dnsp_pkg::QTAIL_PTR;
						phase_d = dnsp_pkg::PH_QTAIL;
					end else begin
						skip_d  = {8'd0, b};
						phase_d = dnsp_pkg::PH_QLABEL;
					end
				end
				dnsp_pkg::PH_QLABEL: begin
					skip_d = sdec;
					if (sdec == 16'd0) begin
						phase_d = dnsp_pkg::PH_QNAME;
					end
				end
				dnsp_pkg::PH_QTAIL: begin
					skip_d = sdec;
					if (sdec == 16'd0) begin
						qleft_d = qdec;
						phase_d = (qdec == 16'd0) ? dnsp_pkg::PH_ANAME : dnsp_pkg::PH_QNAME;
					end
				end
				dnsp_pkg::PH_ANAME: begin
					field_d = 4'd0;
					if (b == 8'd0) begin
						phase_d = dnsp_pkg::PH_AFIXED;
					end else if (b[7:6] == dnsp_pkg::PTR_MARK) begin
						phase_d = dnsp_pkg::PH_APTR;
					end else begin
						skip_d  = {8'd0, b};
						phase_d = dnsp_pkg::PH_ALABEL;
					end
				end
				dnsp_pkg::PH_ALABEL: begin
					skip_d = sdec;
					if (sdec == 16'd0) begin
						phase_d = dnsp_pkg::PH_ANAME;
					end
				end
				dnsp_pkg::PH_APTR: begin
					field_d = 4'd0;
					phase_d = dnsp_pkg::PH_AFIXED;
				end
				dnsp_pkg::PH_AFIXED: begin
					case (field_q)
						dnsp_pkg::FX_TYPE_HI: rtype_d = {b, 8'd0};
						dnsp_pkg::FX_TYPE_LO: rtype_d = {rtype_q[15:8], b};
						dnsp_pkg::FX_CLASS_HI: rclass_d = {b, 8'd0};
						dnsp_pkg::FX_CLASS_LO: rclass_d = {rclass_q[15:8], b};
						dnsp_pkg::FX_DLEN_HI: dlen_hi_d = b;
						default: ;
					endcase
					if (field_q >= dnsp_pkg::FX_LAST_IDX) begin
						field_d = 4'd0;
						if (rtype_q == dnsp_pkg::TYPE_A && rclass_q == dnsp_pkg::CLASS_IN
								&& dlen == dnsp_pkg::A_DATA_LEN) begin
							addr_d  = 32'd0;
							phase_d = dnsp_pkg::PH_AADDR;
						end else if (dlen == 16'd0) begin
							aleft_d = adec;
							phase_d = (adec == 16'd0) ? dnsp_pkg::PH_NOA : dnsp_pkg::PH_ANAME;
						end else begin
							skip_d  = dlen;
							phase_d = dnsp_pkg::PH_ADATA;
						end
					end else begin
						field_d = field_q + 4'd1;
					end
				end
				dnsp_pkg::PH_ADATA: begin
					skip_d = sdec;
					if (sdec == 16'd0) begin
						aleft_d = adec;
						phase_d = (adec == 16'd0) ? dnsp_pkg::PH_NOA : dnsp_pkg::PH_ANAME;
					end
				end
				dnsp_pkg::PH_AADDR: begin
					addr_d = {addr_q[23:0], b};
					if (field_q >= dnsp_pkg::ADDR_LAST_IDX) begin
						decided_d = 1'b1;
					end else begin
						field_d = field_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// outputs: result of the message at the address or at its last byte
	always_comb begin
		found = !decided_q && phase_q == dnsp_pkg::PH_AADDR
			&& field_q >= dnsp_pkg::ADDR_LAST_IDX;
		emit  = item.valid && !decided_q && (found || item.last);
		res.address = 32'd0;
		if (found) begin
			res.status  = dnsp_pkg::ST_FOUND;
			res.address = addr_d;
		end else begin
			case (phase_d)
				dnsp_pkg::PH_HDR:     res.status = dnsp_pkg::ST_SHORT;
				dnsp_pkg::PH_NOTRESP: res.status = dnsp_pkg::ST_NOTRESP;
				dnsp_pkg::PH_RCODE:   res.status = dnsp_pkg::ST_RCODE;
				dnsp_pkg::PH_NOANS:   res.status = dnsp_pkg::ST_NOANS;
				default:              res.status = dnsp_pkg::ST_NOA;
			endcase
		end
	end

	// advance the state; drop back to reset values after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= dnsp_pkg::PH_HDR;
			field_q   <= 4'd0;
			resp_q    <= 1'b0;
			rcode_q   <= 4'd0;
			qleft_q   <= 16'd0;
			aleft_q   <= 16'd0;
			skip_q    <= 16'd0;
			rtype_q   <= 16'd0;
			rclass_q  <= 16'd0;
			dlen_hi_q <= 8'd0;
			addr_q    <= 32'd0;
			decided_q <= 1'b0;
		end else if (adv) begin
			if (item.last) begin
				phase_q   <= dnsp_pkg::PH_HDR;
				field_q   <= 4'd0;
				resp_q    <= 1'b0;
				rcode_q   <= 4'd0;
				qleft_q   <= 16'd0;
				aleft_q   <= 16'd0;
				skip_q    <= 16'd0;
				rtype_q   <= 16'd0;
				rclass_q  <= 16'd0;
				dlen_hi_q <= 8'd0;
				addr_q    <= 32'd0;
				decided_q <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				field_q   <= field_d;
				resp_q    <= resp_d;
				rcode_q   <= rcode_d;
				qleft_q   <= qleft_d;
				aleft_q   <= aleft_d;
				skip_q    <= skip_d;
				rtype_q   <= rtype_d;
				rclass_q  <= rclass_d;
				dlen_hi_q <= dlen_hi_d;
				addr_q    <= addr_d;
				decided_q <= decided_d;
			end
		end
	end

endmodule

[hdl/dnsp_out_stage.sv]
// ----------------------------------------------------------------------------
// dnsp_out_stage: result register of the parser
// Holds one result until the receiver takes it and packs it onto the bus.
// ----------------------------------------------------------------------------
module dnsp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  dnsp_pkg::result_t res,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata    // status [2:0], address [34:3], zero [39:35]
);

	logic              valid_q;
	dnsp_pkg::result_t res_q;

	// room for a new result when empty or being taken now
	assign free = !valid_q || m_tready;

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// capture the result
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {5'd0, res_q.address, res_q.status};

endmodule

[hdl/dns_response_a_record_parser.sv]
// ----------------------------------------------------------------------------
// dns_response_a_record_parser: DNS response parser for IPv4 A records
// Walks a DNS message byte by byte and reports the first A record address.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one message byte per request in s_tdata, s_tlast on the
//   final byte of the message. Master stream: one result per message,
//   status in m_tdata[2:0] and the IPv4 address in m_tdata[34:3].
//   A found address raises m_tvalid after its fourth byte passes the input
//   register and the result register, the byte waiting while the result
//   register is full; any other status follows the last byte alike. Bytes after
//   a found address up to the last byte produce nothing.
//   Throughput is one byte per cycle while no result is held up: each byte
//   passes the input register, one step of the parse state machine and,
//   if it ends the message or completes the address, the result register.
//   Reset clears both registers and returns the parser to the header phase.
//   When the receiver stalls, the held result stays on the bus; bytes keep
//   flowing until one that produces a further result meets the full result
//   register, and then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module dns_response_a_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte [7:0]
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // status [2:0], address [34:3], zero [39:35]
);

	dnsp_pkg::in_item_t item;
	dnsp_pkg::result_t  res;
	logic               emit;
	logic               free;
	logic               adv;

	// move the held byte on unless its result has nowhere to go
	assign adv = item.valid && (!emit || free);

	dnsp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.adv      (adv),
		.item     (item)
	);

	dnsp_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.adv    (adv),
		.emit   (emit),
		.res    (res)
	);

	dnsp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && emit),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// a held byte that does not advance stays in the input register
	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && !adv |=> item.valid && $stable(item.data) && $stable(item.last))
		else $error("input byte lost while stalled");

	// the address is zero unless the record was found
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != dnsp_pkg::ST_FOUND |-> m_tdata[34:3] == 32'd0)
		else $error("address set without a found record");

	// status codes stay within the defined set and padding stays zero
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= dnsp_pkg::ST_NOA && m_tdata[39:35] == 5'd0)
		else $error("bad result encoding");

endmodule
